// ----- rtl/kwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way sorted merge: controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int CFG_W = 3;
	localparam logic [CFG_W-1:0] LANES_RESET = 3'd4;

	// the emit loop yields after MAX_RESULTS - 1 results per request
	localparam int MAX_RESULTS = 64;
	localparam int RES_CNT_W = 6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPLY,
		S_CHECK,
		S_SCAN,
		S_LAST_CMP,
		S_EMIT,
		S_EMPTY
	} state_t;

	typedef struct packed {
		logic accept;
		logic apply;
		logic scan_start;
		logic scan_rd;
		logic emit;
		logic empty;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic drop_now;
		logic stop;
		logic done;
		logic scan_last;
		logic last_pred;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/kwm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_ctrl
// Merge sequencer: takes a request, applies it to the lane FIFOs, then loops
// scan / emit until capped or no lane may emit, and closes a drained merge.
// ----------------------------------------------------------------------------
module kwm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                cfg_ready,
	input  wire kwm_pkg::sts_t  sts,
	output kwm_pkg::cmd_t       cmd
);

	kwm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			kwm_pkg::S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = kwm_pkg::S_APPLY;
				end
			end
			kwm_pkg::S_APPLY: begin
				// a drop result needs the output register
				if (!sts.drop_now || sts.out_free) begin
					cmd.apply = 1'b1;
					state_d   = kwm_pkg::S_CHECK;
				end
			end
			kwm_pkg::S_CHECK: begin
				if (sts.stop) begin
					state_d = sts.done ? kwm_pkg::S_EMPTY : kwm_pkg::S_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = kwm_pkg::S_SCAN;
				end
			end
			kwm_pkg::S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = kwm_pkg::S_LAST_CMP;
				end
			end
			kwm_pkg::S_LAST_CMP: begin
				state_d = kwm_pkg::S_EMIT;
			end
			kwm_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_pred) begin
						cmd.clear = 1'b1;
						state_d   = kwm_pkg::S_IDLE;
					end else begin
						state_d = kwm_pkg::S_CHECK;
					end
				end
			end
			kwm_pkg::S_EMPTY: begin
				if (sts.out_free) begin
					cmd.empty = 1'b1;
					cmd.clear = 1'b1;
					state_d   = kwm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kwm_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/kwm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_dp
// Merge datapath: request registers, lane FIFO memory with per-lane pointers,
// serial minimum scan over lane heads, and the result output register.
// ----------------------------------------------------------------------------
module kwm_dp #(
	parameter int LANES      = 4,
	parameter int FIFO_DEPTH = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire kwm_pkg::cmd_t                 cmd,
	output kwm_pkg::sts_t                      sts,
	input  wire logic                          cfg_we,
	input  wire logic [kwm_pkg::CFG_W-1:0]     lanes_in_use,
	input  wire logic [$clog2(LANES)-1:0]      lane,
	input  wire logic signed [VALUE_BITS-1:0]  element_value,
	input  wire logic                          has_element,
	input  wire logic                          lane_end,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [VALUE_BITS-1:0]       merged_value,
	output logic [$clog2(LANES)-1:0]           source_lane,
	output logic                               value_valid,
	output logic                               last_of_merge,
	output logic                               dropped
);

	localparam int LANE_W     = $clog2(LANES);
	localparam int LANE_SLOTS = 1 << LANE_W;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int MEM_DEPTH  = 1 << (LANE_W + PTR_W);

	function automatic logic [LANE_SLOTS-1:0] act_mask(input logic [kwm_pkg::CFG_W-1:0] v);
		int n;
		logic [LANE_SLOTS-1:0] m;
		n = int'(v);
		if (n == 0) begin
			n = 1;
		end else if (n > LANES) begin
			n = LANES;
		end
		for (int i = 0; i < LANE_SLOTS; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// request registers
	logic [LANE_W-1:0]            lane_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic                         has_q;
	logic                         end_q;

	logic [LANE_SLOTS-1:0] mask_q;

	logic [PTR_W-1:0]      rd_ptr_q [LANE_SLOTS];
	logic [PTR_W-1:0]      wr_ptr_q [LANE_SLOTS];
	logic [CNT_W-1:0]      fill_q   [LANE_SLOTS];
	logic [LANE_SLOTS-1:0] ended_q;

	logic signed [VALUE_BITS-1:0] fifo_mem_q [MEM_DEPTH];

	logic [LANE_W-1:0]            scan_idx_q;
	logic signed [VALUE_BITS-1:0] rd_val_s1;
	logic [LANE_W-1:0]            rd_lane_s1;
	logic                         rd_ok_s1;
	logic signed [VALUE_BITS-1:0] best_val_q;
	logic [LANE_W-1:0]            best_lane_q;
	logic                         best_ok_q;

	logic [kwm_pkg::RES_CNT_W-1:0] res_cnt_q;

	logic lane_act;
	logic drop_now;
	logic push;
	logic ready;
	logic any_head;
	logic done;
	logic rem_zero;
	logic cap;
	logic out_free;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lane_q <= lane;
			val_q  <= element_value;
			has_q  <= has_element;
			end_q  <= lane_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= act_mask(kwm_pkg::LANES_RESET);
		end else if (cfg_we) begin
			mask_q <= act_mask(lanes_in_use);
		end
	end

	// padding slots above LANES are never active, so they stay empty
	assign lane_act = mask_q[lane_q];
	assign drop_now = lane_act && has_q
		&& (ended_q[lane_q] || fill_q[lane_q] == CNT_W'(FIFO_DEPTH));
	assign push     = cmd.apply && lane_act && has_q && !drop_now;

	// lanes switched off in mid-merge keep their contents but take no part
	always_comb begin
		ready    = 1'b1;
		any_head = 1'b0;
		done     = 1'b1;
		rem_zero = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			if (mask_q[i] && fill_q[i] == '0 && !ended_q[i]) begin
				ready = 1'b0;
			end
			if (mask_q[i] && fill_q[i] != '0) begin
				any_head = 1'b1;
			end
			if (mask_q[i] && (fill_q[i] != '0 || !ended_q[i])) begin
				done = 1'b0;
			end
			// after popping the best head, is everything drained?
			if (LANE_W'(i) == best_lane_q) begin
				if (fill_q[i] != CNT_W'(1)) begin
					rem_zero = 1'b0;
				end
			end else if (mask_q[i] && fill_q[i] != '0) begin
				rem_zero = 1'b0;
			end
		end
	end

	assign cap = res_cnt_q >= kwm_pkg::RES_CNT_W'(kwm_pkg::MAX_RESULTS - 1);

	// per-lane pointers, counts and end flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_SLOTS; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
			end
			ended_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < LANE_SLOTS; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
			end
			ended_q <= '0;
		end else begin
			for (int i = 0; i < LANE_SLOTS; i++) begin
				if (push && lane_q == LANE_W'(i)) begin
					wr_ptr_q[i] <= ptr_inc(wr_ptr_q[i]);
					fill_q[i]   <= fill_q[i] + CNT_W'(1);
				end else if (cmd.emit && best_lane_q == LANE_W'(i)) begin
					rd_ptr_q[i] <= ptr_inc(rd_ptr_q[i]);
					fill_q[i]   <= fill_q[i] - CNT_W'(1);
				end
				if (cmd.apply && lane_act && end_q && lane_q == LANE_W'(i)) begin
					ended_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem_q[{lane_q, wr_ptr_q[lane_q]}] <= val_q;
		end
		if (cmd.scan_rd) begin
			rd_val_s1 <= fifo_mem_q[{scan_idx_q, rd_ptr_q[scan_idx_q]}];
		end
	end

	// serial minimum over lane heads; strict compare keeps the lowest lane on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_ok_s1   <= 1'b0;
			rd_lane_s1 <= '0;
			best_ok_q  <= 1'b0;
			best_lane_q <= '0;
		end else begin
			rd_ok_s1   <= cmd.scan_rd && mask_q[scan_idx_q] && fill_q[scan_idx_q] != '0;
			rd_lane_s1 <= scan_idx_q;
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + LANE_W'(1);
			end
			if (cmd.scan_start) begin
				best_ok_q <= 1'b0;
			end else if (rd_ok_s1 && (!best_ok_q || rd_val_s1 < best_val_q)) begin
				best_ok_q   <= 1'b1;
				best_lane_q <= rd_lane_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.scan_start && rd_ok_s1 && (!best_ok_q || rd_val_s1 < best_val_q)) begin
			best_val_q <= rd_val_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (cmd.apply) begin
			res_cnt_q <= drop_now ? kwm_pkg::RES_CNT_W'(1) : '0;
		end else if (cmd.emit) begin
			res_cnt_q <= res_cnt_q + kwm_pkg::RES_CNT_W'(1);
		end
	end

	// output register
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((cmd.apply && drop_now) || cmd.emit || cmd.empty) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && drop_now) begin
			merged_value  <= '0;
			source_lane   <= lane_q;
			value_valid   <= 1'b0;
			last_of_merge <= 1'b0;
			dropped       <= 1'b1;
		end else if (cmd.emit) begin
			merged_value  <= best_val_q;
			source_lane   <= best_lane_q;
			value_valid   <= 1'b1;
			last_of_merge <= sts.last_pred;
			dropped       <= 1'b0;
		end else if (cmd.empty) begin
			merged_value  <= '0;
			source_lane   <= '0;
			value_valid   <= 1'b0;
			last_of_merge <= 1'b1;
			dropped       <= 1'b0;
		end
	end

	always_comb begin
		sts.out_free  = out_free;
		sts.drop_now  = drop_now;
		sts.stop      = cap || !ready || !any_head;
		sts.done      = done;
		sts.scan_last = scan_idx_q == LANE_W'(LANES - 1);
		sts.last_pred = rem_zero && (&(ended_q | ~mask_q));
	end

endmodule
`default_nettype wire

// ----- rtl/k_way_sorted_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges up to LANES ascending signed streams into one ascending stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per lane item, carrying
//   lane, element_value, has_element and lane_end. Requests are taken one at a
//   time; in_stall is low only while the sequencer is idle.
//   Output channel (out_valid / out_stall): merged elements, drop reports and
//   the end-of-merge mark, held in an output register.
//   Config channel (cfg_valid / cfg_ready): lanes_in_use, write while idle.
// Sequence:
//   A request that emits nothing passes through accept, apply and check.
//   Each emitted element adds scan, last compare and emit: the heads are
//   read from the single-port lane FIFO memory one lane per cycle and
//   compared serially. An empty result adds S_EMPTY; a drop loads in apply.
// Reset clears all lane FIFOs and flags and sets lanes_in_use to 4; FIFO
// contents are not cleared and need no sweep. A stalled receiver holds the
// output register and the sequencer waits until it frees up.
// ----------------------------------------------------------------------------
module k_way_sorted_merge #(
	parameter int LANES      = 4,
	parameter int FIFO_DEPTH = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [kwm_pkg::CFG_W-1:0]     lanes_in_use,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [$clog2(LANES)-1:0]      lane,
	input  wire logic signed [VALUE_BITS-1:0]  element_value,
	input  wire logic                          has_element,
	input  wire logic                          lane_end,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [VALUE_BITS-1:0]       merged_value,
	output logic [$clog2(LANES)-1:0]           source_lane,
	output logic                               value_valid,
	output logic                               last_of_merge,
	output logic                               dropped
);

	kwm_pkg::cmd_t cmd;
	kwm_pkg::sts_t sts;

	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kwm_dp #(
		.LANES      (LANES),
		.FIFO_DEPTH (FIFO_DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.lanes_in_use  (lanes_in_use),
		.lane          (lane),
		.element_value (element_value),
		.has_element   (has_element),
		.lane_end      (lane_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.merged_value  (merged_value),
		.source_lane   (source_lane),
		.value_valid   (value_valid),
		.last_of_merge (last_of_merge),
		.dropped       (dropped)
	);

endmodule
`default_nettype wire

// ----- rtl/kwm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks on the merge result stream, bound to the top level.
// ----------------------------------------------------------------------------
module kwm_checker #(
	parameter int LANES      = 4,
	parameter int VALUE_BITS = 32
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic signed [VALUE_BITS-1:0] merged_value,
	input wire logic [$clog2(LANES)-1:0]     source_lane,
	input wire logic                         value_valid,
	input wire logic                         last_of_merge,
	input wire logic                         dropped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(merged_value)
			&& $stable(last_of_merge) && $stable(dropped))
		else $error("stalled result changed");

	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(value_valid && dropped))
		else $error("result both element and drop");

	a_drop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !last_of_merge)
		else $error("drop result marked last");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_valid && !dropped |-> last_of_merge && source_lane == '0)
		else $error("empty result not a final mark");

	a_novalue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_valid |-> merged_value == '0)
		else $error("nonzero value without element");

endmodule

bind k_way_sorted_merge kwm_checker #(
	.LANES      (LANES),
	.VALUE_BITS (VALUE_BITS)
) u_kwm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.merged_value  (merged_value),
	.source_lane   (source_lane),
	.value_valid   (value_valid),
	.last_of_merge (last_of_merge),
	.dropped       (dropped)
);
`default_nettype wire
